>>> hw/rtl/binary_multipattern_bcd_matcher_top_defines.svh
// Assertion macros shared by the matcher RTL.
`ifndef BINARY_MULTIPATTERN_BCD_MATCHER_TOP_DEFINES_SVH
`define BINARY_MULTIPATTERN_BCD_MATCHER_TOP_DEFINES_SVH

// Check that cond holds whenever trig holds, in the same cycle.
`define BMPM_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("bmpm assertion failed");

// Check that cond holds in the cycle after trig.
`define BMPM_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("bmpm assertion failed");

`endif

>>> hw/rtl/bmpm_pkg.sv
// Shared constants of the binary multi-pattern BCD matcher.
package bmpm_pkg;

  localparam int MaxNodesDef = 2048;
  localparam int NodeOutW    = 11;
  localparam int DigitW      = 4;
  localparam int ReqW        = 2;

  // Request kinds carried in tuser
  localparam logic [ReqW-1:0] ReqClear = 2'd0;
  localparam logic [ReqW-1:0] ReqBit   = 2'd1;
  localparam logic [ReqW-1:0] ReqDigit = 2'd2;

endpackage

>>> hw/rtl/binary_multipattern_bcd_matcher_top.sv
// Top level of the binary Aho-Corasick matcher fed with BCD digits.
//
// One transaction at a time, each answered by exactly one result. All trie
// state (children, failure link, terminal mark) sits in one node RAM with a
// registered read, so the cost is set by the number of dependent RAM reads: a
// digit takes up to five node reads (the current node, then one per BCD bit).
// The first digit after loading first builds the failure links breadth
// first through a queue RAM. After reset the root entry is written in the
// INIT state before the first transaction is taken.
`include "binary_multipattern_bcd_matcher_top_defines.svh"
module binary_multipattern_bcd_matcher_top #(
  parameter int MAX_NODES = bmpm_pkg::MaxNodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [0] pattern_bit, [4:1] digit, [5] restart
  input  logic        s_axis_tlast,  // pattern_last
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [10:0] node_now, [11] blocked, [12] overflow
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = AW + 1;
  localparam int EW = 3 * AW + 1;
  localparam int OW = bmpm_pkg::NodeOutW;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_LD_EVAL  = 4'd2;
  localparam logic [3:0] ST_LD_NEW   = 4'd3;
  localparam logic [3:0] ST_LD_TERM  = 4'd4;
  localparam logic [3:0] ST_BF_POP   = 4'd5;
  localparam logic [3:0] ST_BF_GETP  = 4'd6;
  localparam logic [3:0] ST_BF_GETF  = 4'd7;
  localparam logic [3:0] ST_BF_FLAT  = 4'd8;
  localparam logic [3:0] ST_BF_BIT   = 4'd9;
  localparam logic [3:0] ST_BF_TF    = 4'd10;
  localparam logic [3:0] ST_BF_SETS  = 4'd11;
  localparam logic [3:0] ST_BF_NEXTB = 4'd12;
  localparam logic [3:0] ST_WK_START = 4'd13;
  localparam logic [3:0] ST_WK_CHK   = 4'd14;
  localparam logic [3:0] ST_RESP     = 4'd15;

  logic [3:0]    state_q, state_d;
  logic          pbit_q, pbit_d, plast_q, plast_d, restart_q, restart_d;
  logic [3:0]    digit_q, digit_d;
  logic [AW-1:0] cursor_q, cursor_d, count_q, count_d, walk_q, walk_d;
  logic          blocked_q, blocked_d, built_q, built_d, ovf_q, ovf_d;
  logic [CW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] p_q, p_d, f_q, f_d, s_q, s_d, cur_q, cur_d, shown_q, shown_d;
  logic [EW-1:0] pent_q, pent_d, fent_q, fent_d;
  logic          bit_q, bit_d, tf_q, tf_d;
  logic [2:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d, out_blk_q, out_blk_d, out_ovf_q, out_ovf_d;
  logic [OW-1:0] out_node_q, out_node_d;

  logic          n_we, n_re, q_we, q_re;
  logic [AW-1:0] n_waddr, n_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
  logic [EW-1:0] n_wdata, n_rdata;

  logic          in_acc;
  logic [CW-1:0] count_inc;
  logic [AW-1:0] e_c0, e_c1, e_fail, nx, bs, bf, wk_next;
  logic          e_term;
  logic [AW+OW-1:0] shown_ext;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign count_inc     = {1'b0, count_q} + CW'(1);

  // Split the node RAM read data
  assign e_c0   = n_rdata[AW-1:0];
  assign e_c1   = n_rdata[2*AW-1:AW];
  assign e_fail = n_rdata[3*AW-1:2*AW];
  assign e_term = n_rdata[3*AW];
  assign nx     = pbit_q ? e_c1 : e_c0;
  assign bs     = bit_q ? pent_q[2*AW-1:AW] : pent_q[AW-1:0];
  assign bf     = bit_q ? fent_q[2*AW-1:AW] : fent_q[AW-1:0];
  assign wk_next = digit_q[2'd3 - step_q[1:0]] ? e_c1 : e_c0;
  assign shown_ext = {{OW{1'b0}}, shown_q};

  // Sequencer: load, link build, digit walk, result
  always_comb begin
    state_d = state_q;
    pbit_d = pbit_q; plast_d = plast_q; restart_d = restart_q; digit_d = digit_q;
    cursor_d = cursor_q; count_d = count_q; walk_d = walk_q;
    blocked_d = blocked_q; built_d = built_q; ovf_d = ovf_q;
    head_d = head_q; tail_d = tail_q; p_d = p_q; f_d = f_q; s_d = s_q;
    cur_d = cur_q; shown_d = shown_q; pent_d = pent_q; fent_d = fent_q;
    bit_d = bit_q; tf_d = tf_q; step_d = step_q;
    out_valid_d = out_valid_q; out_blk_d = out_blk_q; out_ovf_d = out_ovf_q;
    out_node_d = out_node_q;
    n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_re = 1'b0; n_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        n_we = 1'b1;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          pbit_d    = s_axis_tdata[0];
          digit_d   = s_axis_tdata[4:1];
          restart_d = s_axis_tdata[5];
          plast_d   = s_axis_tlast;
          unique case (s_axis_tuser)
            bmpm_pkg::ReqClear: begin
              n_we = 1'b1;
              count_d = '0; cursor_d = '0; walk_d = '0;
              blocked_d = 1'b0; built_d = 1'b0; ovf_d = 1'b0;
              shown_d = '0;
              state_d = ST_RESP;
            end
            bmpm_pkg::ReqBit: begin
              if (!built_q && !ovf_q) begin
                n_re = 1'b1; n_raddr = cursor_q;
                state_d = ST_LD_EVAL;
              end else begin
                cursor_d = s_axis_tlast ? '0 : cursor_q;
                shown_d  = s_axis_tlast ? '0 : cursor_q;
                state_d  = ST_RESP;
              end
            end
            bmpm_pkg::ReqDigit: begin
              if (!built_q) begin
                q_we = 1'b1; q_waddr = '0; q_wdata = '0;
                head_d = '0; tail_d = CW'(1);
                state_d = ST_BF_POP;
              end else begin
                state_d = ST_WK_START;
              end
            end
            default: begin
              shown_d = walk_q;
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_LD_EVAL: begin
        if (nx == '0) begin
          if (count_inc < CW'(MAX_NODES)) begin
            // Hook a fresh node under the cursor
            n_we = 1'b1; n_waddr = cursor_q;
            n_wdata = pbit_q ? {e_term, e_fail, count_inc[AW-1:0], e_c0}
                             : {e_term, e_fail, e_c1, count_inc[AW-1:0]};
            count_d = count_inc[AW-1:0];
            state_d = ST_LD_NEW;
          end else begin
            ovf_d    = 1'b1;
            cursor_d = plast_q ? '0 : cursor_q;
            shown_d  = plast_q ? '0 : cursor_q;
            state_d  = ST_RESP;
          end
        end else if (plast_q) begin
          n_re = 1'b1; n_raddr = nx; s_d = nx;
          state_d = ST_LD_TERM;
        end else begin
          cursor_d = nx; shown_d = nx;
          state_d = ST_RESP;
        end
      end
      ST_LD_NEW: begin
        n_we = 1'b1; n_waddr = count_q;
        n_wdata = {plast_q, {(3*AW){1'b0}}};
        cursor_d = plast_q ? '0 : count_q;
        shown_d  = plast_q ? '0 : count_q;
        state_d  = ST_RESP;
      end
      ST_LD_TERM: begin
        n_we = 1'b1; n_waddr = s_q;
        n_wdata = {1'b1, n_rdata[3*AW-1:0]};
        cursor_d = '0; shown_d = '0;
        state_d = ST_RESP;
      end
      ST_BF_POP: begin
        if (head_q < tail_q && head_q < CW'(MAX_NODES)) begin
          q_re = 1'b1; q_raddr = head_q[AW-1:0];
          head_d = head_q + CW'(1);
          state_d = ST_BF_GETP;
        end else begin
          built_d = 1'b1;
          state_d = ST_WK_START;
        end
      end
      ST_BF_GETP: begin
        p_d = q_rdata;
        n_re = 1'b1; n_raddr = q_rdata;
        state_d = ST_BF_GETF;
      end
      ST_BF_GETF: begin
        pent_d = n_rdata;
        bit_d  = 1'b0;
        if (p_q != '0) begin
          n_re = 1'b1; n_raddr = e_fail;
          state_d = ST_BF_FLAT;
        end else begin
          state_d = ST_BF_BIT;
        end
      end
      ST_BF_FLAT: begin
        fent_d = n_rdata;
        state_d = ST_BF_BIT;
      end
      ST_BF_BIT: begin
        if (bs != '0) begin
          f_d = (p_q == '0) ? '0 : bf;
          s_d = bs;
          n_re = 1'b1; n_raddr = (p_q == '0) ? '0 : bf;
          state_d = ST_BF_TF;
        end else begin
          // Fill the missing edge from the failure target (root edges stay at 0)
          if (p_q != '0) begin
            if (bit_q) pent_d[2*AW-1:AW] = bf;
            else       pent_d[AW-1:0]    = bf;
          end
          state_d = ST_BF_NEXTB;
        end
      end
      ST_BF_TF: begin
        tf_d = e_term;
        n_re = 1'b1; n_raddr = s_q;
        state_d = ST_BF_SETS;
      end
      ST_BF_SETS: begin
        n_we = 1'b1; n_waddr = s_q;
        n_wdata = {e_term | tf_q, f_q, e_c1, e_c0};
        if (tail_q < CW'(MAX_NODES)) begin
          q_we = 1'b1; q_waddr = tail_q[AW-1:0]; q_wdata = s_q;
          tail_d = tail_q + CW'(1);
        end
        state_d = ST_BF_NEXTB;
      end
      ST_BF_NEXTB: begin
        if (!bit_q) begin
          bit_d = 1'b1;
          state_d = ST_BF_BIT;
        end else begin
          n_we = 1'b1; n_waddr = p_q; n_wdata = pent_q;
          state_d = ST_BF_POP;
        end
      end
      ST_WK_START: begin
        if (restart_q) begin
          walk_d = '0; blocked_d = 1'b0;
        end
        if (blocked_q && !restart_q) begin
          shown_d = walk_q;
          state_d = ST_RESP;
        end else begin
          cur_d  = restart_q ? '0 : walk_q;
          n_re   = 1'b1; n_raddr = restart_q ? '0 : walk_q;
          step_d = '0;
          state_d = ST_WK_CHK;
        end
      end
      ST_WK_CHK: begin
        if (e_term || step_q == 3'd4) begin
          blocked_d = e_term;
          walk_d = cur_q; shown_d = cur_q;
          state_d = ST_RESP;
        end else begin
          cur_d  = wk_next;
          n_re   = 1'b1; n_raddr = wk_next;
          step_d = step_q + 3'd1;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_node_d  = shown_ext[OW-1:0];
          out_blk_d   = blocked_q;
          out_ovf_d   = ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cursor_q <= '0; count_q <= '0; walk_q <= '0;
      blocked_q <= 1'b0; built_q <= 1'b0; ovf_q <= 1'b0;
      head_q <= '0; tail_q <= '0; step_q <= '0; bit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cursor_q <= cursor_d; count_q <= count_d; walk_q <= walk_d;
      blocked_q <= blocked_d; built_q <= built_d; ovf_q <= ovf_d;
      head_q <= head_d; tail_q <= tail_d; step_q <= step_d; bit_q <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pbit_q <= pbit_d; plast_q <= plast_d; restart_q <= restart_d; digit_q <= digit_d;
    p_q <= p_d; f_q <= f_d; s_q <= s_d; cur_q <= cur_d; shown_q <= shown_d;
    pent_q <= pent_d; fent_q <= fent_d; tf_q <= tf_d;
    out_node_q <= out_node_d; out_blk_q <= out_blk_d; out_ovf_q <= out_ovf_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_ovf_q, out_blk_q, out_node_q};

  bmpm_ram #(.Width(EW), .Depth(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .re_i    (n_re),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  bmpm_ram #(.Width(AW), .Depth(MAX_NODES)) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  `BMPM_ASSERT_IMP(a_count_range, 1'b1, {1'b0, count_q} < CW'(MAX_NODES))
  `BMPM_ASSERT_NEXT(a_clear_resets, in_acc && s_axis_tuser == bmpm_pkg::ReqClear, count_q == '0 && !built_q && !ovf_q)
  `BMPM_ASSERT_IMP(a_step_range, state_q == ST_WK_CHK, step_q <= 3'd4)
  `BMPM_ASSERT_IMP(a_ovf_sticky, $fell(ovf_q), $past(in_acc && s_axis_tuser == bmpm_pkg::ReqClear))

endmodule

>>> hw/rtl/bmpm_ram.sv
// Generic simple dual-port RAM with registered read.
module bmpm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> tb/binary_multipattern_bcd_matcher_top_tb.sv
// Self-checking testbench for the binary multi-pattern BCD matcher.
`timescale 1ns / 1ps

module binary_multipattern_bcd_matcher_top_tb;

  localparam int          NodeCap  = bmpm_pkg::MaxNodesDef;
  localparam logic [1:0]  ReqNone  = 2'd3;
  localparam int          CycleCap = 600000;

  // Predicts the matcher and holds the answers still owed by the block
  class matcher_scoreboard;
    bit [10:0]  kid0 [NodeCap];
    bit [10:0]  kid1 [NodeCap];
    bit [10:0]  fail_to [NodeCap];
    bit         term [NodeCap];
    bit [10:0]  bfs [NodeCap];
    int unsigned nodes;
    bit [10:0]  cursor;
    bit [10:0]  walk;
    bit         blk;
    bit         built;
    bit         ovf;
    bit [12:0]  owed [$];
    int         errors;

    function void wipe();
      kid0[0] = '0; kid1[0] = '0; fail_to[0] = '0; term[0] = 1'b0;
      nodes = 0; cursor = '0; walk = '0; blk = 1'b0; built = 1'b0; ovf = 1'b0;
    endfunction

    function bit [10:0] edge_of(bit [10:0] n, bit b);
      return b ? kid1[n] : kid0[n];
    endfunction

    function void set_edge(bit [10:0] n, bit b, bit [10:0] v);
      if (b) kid1[n] = v;
      else kid0[n] = v;
    endfunction

    // Breadth-first failure links, goto completion and terminal propagation
    function void link_up();
      int unsigned head, tail;
      bit [10:0] p, s, f;
      head = 0; tail = 0;
      fail_to[0] = '0;
      bfs[tail++] = '0;
      while (head < tail && head < NodeCap) begin
        p = bfs[head++];
        for (int b = 0; b < 2; b++) begin
          s = edge_of(p, b[0]);
          if (s != 0) begin
            f = (p == 0) ? 11'd0 : edge_of(fail_to[p], b[0]);
            fail_to[s] = f;
            if (term[f]) term[s] = 1'b1;
            if (tail < NodeCap) bfs[tail++] = s;
          end else begin
            set_edge(p, b[0], edge_of(fail_to[p], b[0]));
          end
        end
      end
      built = 1'b1;
    endfunction

    // Note an accepted transaction and queue its expected result
    function void note(bit [1:0] req, bit pbit, bit plast, bit [3:0] dig, bit rs);
      bit [10:0] shown, c, nx, cur;
      shown = walk;
      case (req)
        bmpm_pkg::ReqClear: begin
          wipe();
          shown = '0;
        end
        bmpm_pkg::ReqBit: begin
          if (!built && !ovf) begin
            c = cursor;
            nx = edge_of(c, pbit);
            if (nx == 0) begin
              if (nodes + 1 < NodeCap) begin
                nodes++;
                kid0[nodes] = '0; kid1[nodes] = '0;
                fail_to[nodes] = '0; term[nodes] = 1'b0;
                set_edge(c, pbit, nodes[10:0]);
                nx = nodes[10:0];
              end else begin
                ovf = 1'b1;
              end
            end
            if (!ovf) begin
              cursor = nx;
              if (plast) begin
                term[cursor] = 1'b1;
                cursor = '0;
              end
            end else if (plast) begin
              cursor = '0;
            end
          end else if (plast) begin
            cursor = '0;
          end
          shown = cursor;
        end
        bmpm_pkg::ReqDigit: begin
          if (!built) link_up();
          if (rs) begin
            walk = '0;
            blk = 1'b0;
          end
          if (!blk && term[walk]) blk = 1'b1;
          if (!blk) begin
            cur = walk;
            for (int i = 3; i >= 0; i--) begin
              cur = edge_of(cur, dig[i]);
              if (term[cur]) begin
                blk = 1'b1;
                break;
              end
            end
            walk = cur;
          end
          shown = walk;
        end
        default: ;
      endcase
      owed.push_back({ovf, blk, shown});
    endfunction

    // Compare one result with the oldest expectation
    function void check(bit [15:0] data);
      bit [12:0] exp_r;
      if (owed.size() == 0) begin
        $error("result %h arrived with nothing expected", data);
        errors++;
        return;
      end
      exp_r = owed.pop_front();
      if (data[10:0] != exp_r[10:0]) begin
        $error("node_now: expected %0d, actual %0d", exp_r[10:0], data[10:0]);
        errors++;
      end
      if (data[11] != exp_r[11]) begin
        $error("blocked: expected %0d, actual %0d", exp_r[11], data[11]);
        errors++;
      end
      if (data[12] != exp_r[12]) begin
        $error("overflow: expected %0d, actual %0d", exp_r[12], data[12]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  matcher_scoreboard sb = new();
  int  cycles;
  int  burst_left;
  int  sent_items;
  bit  no_gaps;
  bit  no_stalls;

  binary_multipattern_bcd_matcher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Note accepted transactions and check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note(s_axis_tuser, s_axis_tdata[0], s_axis_tlast, s_axis_tdata[4:1],
              s_axis_tdata[5]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  // Stall the result side in runs of random length
  initial begin
    int run;
    bit hold;
    forever begin
      run = $urandom_range(1, 12);
      hold = ($urandom_range(0, 2) == 0) && !no_stalls;
      repeat (run) begin
        @(negedge clk_i);
        m_axis_tready <= !hold;
      end
    end
  end

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("binary_multipattern_bcd_matcher_top: mismatch");
      $finish;
    end
  end

  // Drive one transaction, inserting burst gaps on the way
  task automatic send(bit [1:0] req, bit pbit, bit plast, bit [3:0] dig, bit rs);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(5, 20))
          @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tlast  <= plast;
    s_axis_tdata  <= {2'b00, rs, dig, pbit};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_items++;
  endtask

  // Load one pattern, random bits of the given length
  task automatic load_pattern(int len);
    for (int i = 0; i < len; i++)
      send(bmpm_pkg::ReqBit, 1'($urandom_range(0, 1)), i == len - 1,
           4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int npat, ndig;
    cycles = 0;
    burst_left = 0;
    sent_items = 0;
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two patterns, matches, blocked walk, restart, odd requests
    send(bmpm_pkg::ReqClear, 1'b1, 1'b1, 4'd15, 1'b1);
    send(bmpm_pkg::ReqBit, 1'b0, 1'b0, 4'd0, 1'b0);
    send(bmpm_pkg::ReqBit, 1'b1, 1'b0, 4'd0, 1'b0);
    send(bmpm_pkg::ReqBit, 1'b1, 1'b1, 4'd0, 1'b0);
    send(bmpm_pkg::ReqBit, 1'b1, 1'b0, 4'd15, 1'b1);
    send(bmpm_pkg::ReqBit, 1'b0, 1'b0, 4'd15, 1'b1);
    send(bmpm_pkg::ReqBit, 1'b0, 1'b0, 4'd15, 1'b1);
    send(bmpm_pkg::ReqBit, 1'b1, 1'b1, 4'd15, 1'b1);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd0, 1'b0);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd9, 1'b0);
    send(bmpm_pkg::ReqDigit, 1'b1, 1'b1, 4'd2, 1'b0);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd8, 1'b1);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd15, 1'b1);
    send(ReqNone, 1'b1, 1'b1, 4'd15, 1'b1);
    send(bmpm_pkg::ReqBit, 1'b1, 1'b1, 4'd7, 1'b0);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd12, 1'b1);
    send(bmpm_pkg::ReqDigit, 1'b0, 1'b0, 4'd3, 1'b0);
    send(bmpm_pkg::ReqClear, 1'b0, 1'b0, 4'd0, 1'b0);
    send(bmpm_pkg::ReqDigit, 1'b1, 1'b1, 4'd10, 1'b1);
    send(ReqNone, 1'b0, 1'b0, 4'd0, 1'b0);
    send(bmpm_pkg::ReqClear, 1'b0, 1'b0, 4'd0, 1'b0);

    // Random: load phases followed by digit walks, with some noise
    while (sent_items < 400) begin
      no_gaps   = ($urandom_range(0, 4) == 0);
      no_stalls = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0)
        send(bmpm_pkg::ReqClear, 1'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      npat = $urandom_range(1, 6);
      for (int p = 0; p < npat; p++) begin
        load_pattern($urandom_range(0, 4) == 0 ? $urandom_range(1, 2)
                                               : $urandom_range(3, 10));
        if ($urandom_range(0, 9) == 0)
          send(ReqNone, 1'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
      end
      ndig = $urandom_range(5, 30);
      for (int d = 0; d < ndig; d++) begin
        case ($urandom_range(0, 19))
          0: send(ReqNone, 1'($urandom), 1'($urandom), 4'($urandom), 1'($urandom));
          1: send(bmpm_pkg::ReqBit, 1'($urandom), 1'($urandom), 4'($urandom),
                  1'($urandom));
          default: send(bmpm_pkg::ReqDigit, 1'($urandom), 1'($urandom),
                        $urandom_range(0, 7) == 0 ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9)),
                        $urandom_range(0, 6) == 0);
        endcase
      end
    end

    // Drain: wait for every result, then a short settle
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0)
      $display("binary_multipattern_bcd_matcher_top: match");
    else
      $display("binary_multipattern_bcd_matcher_top: mismatch");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bmpm_pkg.sv
hw/rtl/bmpm_ram.sv
hw/rtl/binary_multipattern_bcd_matcher_top.sv
tb/binary_multipattern_bcd_matcher_top_tb.sv
